// ----- design/bavg_pkg.sv -----
// shared constants, register indexes and controller/datapath interface types
package bavg_pkg;

  // image geometry
  localparam int unsigned ColW     = 12;
  localparam int unsigned MaxWidth = 1 << ColW;
  localparam int unsigned WidthW   = ColW + 1;

  // block geometry
  localparam int unsigned CntW     = 4;
  localparam int unsigned MaxBlock = 1 << CntW;
  localparam int unsigned BlkW     = CntW + 1;

  // data widths
  localparam int unsigned PixW  = 8;
  localparam int unsigned HsumW = PixW + CntW;
  localparam int unsigned SumW  = PixW + 2 * CntW;
  localparam int unsigned SqW   = 2 * CntW + 1;
  localparam int unsigned ProdW = WidthW + BlkW;

  // serial divider
  localparam int unsigned DivNW   = SumW;
  localparam int unsigned DivDW   = SqW;
  localparam int unsigned DivCntW = $clog2(DivNW);

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = WidthW;

  localparam logic [CfgIdxW-1:0] RegBlockSize  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegImageWidth = CfgIdxW'(1);

  localparam logic [BlkW-1:0]   BlockSizeRst  = BlkW'(2);
  localparam logic [WidthW-1:0] ImageWidthRst = WidthW'(640);

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture pixel, fold counters
    logic col_start;  // start in_col / block_size
    logic cap_oc;     // capture output column from divider
    logic mul;        // register column product, read line buffer
    logic wr;         // write partial block sum to line buffer
    logic avg_start;  // start block sum / block_size^2
    logic emit;       // load output register
    logic adv;        // advance counters and sums
  } bavg_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
    logic in_range;
    logic blk_end;
    logic rib_last;
    logic out_free;
  } bavg_sts_t;

endpackage

// ----- design/bavg_div.sv -----
// serial restoring divider, one quotient bit per cycle
module bavg_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bavg_pkg::DivNW-1:0]   dividend_i,
  input  logic [bavg_pkg::DivDW-1:0]   divisor_i,
  output logic                         done_o,
  output logic [bavg_pkg::DivNW-1:0]   quotient_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [bavg_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [bavg_pkg::DivDW-1:0]   rem_q, rem_d;
  logic [bavg_pkg::DivNW-1:0]   quo_q, quo_d;
  logic [bavg_pkg::DivDW-1:0]   den_q, den_d;
  logic [bavg_pkg::DivDW:0]     rem_sh;
  logic [bavg_pkg::DivDW:0]     rem_sub;
  logic                         ge;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_q, quo_q[bavg_pkg::DivNW-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  // step sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[bavg_pkg::DivDW-1:0] : rem_sh[bavg_pkg::DivDW-1:0];
      quo_d = {quo_q[bavg_pkg::DivNW-2:0], ge};
      cnt_d = cnt_q + bavg_pkg::DivCntW'(1);
      if (cnt_q == bavg_pkg::DivCntW'(bavg_pkg::DivNW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // a new division never starts on top of a running one
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider restarted while busy");

endmodule

// ----- design/bavg_datapath.sv -----
// counters, line buffer of column sums, divider and output register
module bavg_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [bavg_pkg::PixW-1:0]       pixel_i,
  input  logic                            frame_start_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bavg_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bavg_pkg::CfgDataW-1:0]   cfg_data_i,
  input  bavg_pkg::bavg_cmd_t             cmd_i,
  output bavg_pkg::bavg_sts_t             sts_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bavg_pkg::PixW-1:0]       average_o,
  output logic [bavg_pkg::ColW-1:0]       out_col_o,
  output logic [bavg_pkg::ColW-1:0]       out_row_o,
  output logic                            row_end_o
);

  // configuration registers
  logic [bavg_pkg::BlkW-1:0]   block_size_q;
  logic [bavg_pkg::WidthW-1:0] image_width_q;

  // per-transaction operands
  logic [bavg_pkg::BlkW-1:0]   bs_q;
  logic [bavg_pkg::WidthW-1:0] w_q;
  logic [bavg_pkg::SqW-1:0]    bsq_q;
  logic [bavg_pkg::PixW-1:0]   px_q;
  logic [bavg_pkg::ColW-1:0]   oc_q;
  logic [bavg_pkg::ProdW-1:0]  p1_q;
  logic [bavg_pkg::SumW-1:0]   rdata_q;

  // running counters
  logic [bavg_pkg::ColW-1:0]   icol_q, icol_d;
  logic [bavg_pkg::CntW-1:0]   cic_q, cic_d;
  logic [bavg_pkg::CntW-1:0]   rib_q, rib_d;
  logic [bavg_pkg::HsumW-1:0]  hsum_q, hsum_d;
  logic [bavg_pkg::ColW-1:0]   orc_q, orc_d;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic [bavg_pkg::PixW-1:0]   average_q;
  logic [bavg_pkg::ColW-1:0]   out_col_q;
  logic [bavg_pkg::ColW-1:0]   out_row_q;
  logic                        row_end_q;

  // line buffer of partial block sums
  logic [bavg_pkg::SumW-1:0]   col_mem [bavg_pkg::MaxWidth];

  logic [bavg_pkg::BlkW-1:0]   bs_e;
  logic [bavg_pkg::WidthW-1:0] w_e;
  logic [2*bavg_pkg::BlkW-1:0] sq_full;
  logic [bavg_pkg::ProdW-1:0]  p1_d;
  logic [bavg_pkg::ProdW-1:0]  p2;
  logic [bavg_pkg::BlkW-1:0]   bs_m1;
  logic                        in_range, blk_end, rib_last, last_col;
  logic [bavg_pkg::HsumW-1:0]  hsum_p;
  logic [bavg_pkg::SumW-1:0]   sum;
  logic [bavg_pkg::WidthW-1:0] icol_inc;
  logic                        div_done;
  logic [bavg_pkg::DivNW-1:0]  div_quo;
  logic [bavg_pkg::DivNW-1:0]  div_num;
  logic [bavg_pkg::DivDW-1:0]  div_den;

  logic [bavg_pkg::ColW-1:0]   icol_l;
  logic [bavg_pkg::CntW-1:0]   cic_l, rib_l;
  logic [bavg_pkg::HsumW-1:0]  hsum_l;
  logic [bavg_pkg::ColW-1:0]   orc_l;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q  <= bavg_pkg::BlockSizeRst;
      image_width_q <= bavg_pkg::ImageWidthRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bavg_pkg::RegBlockSize:  block_size_q  <= cfg_data_i[bavg_pkg::BlkW-1:0];
        bavg_pkg::RegImageWidth: image_width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective register values, clamped into range
  always_comb begin
    if (block_size_q == '0) begin
      bs_e = bavg_pkg::BlkW'(1);
    end else if (block_size_q > bavg_pkg::BlkW'(bavg_pkg::MaxBlock)) begin
      bs_e = bavg_pkg::BlkW'(bavg_pkg::MaxBlock);
    end else begin
      bs_e = block_size_q;
    end
    if (image_width_q == '0) begin
      w_e = bavg_pkg::WidthW'(1);
    end else if (image_width_q > bavg_pkg::WidthW'(bavg_pkg::MaxWidth)) begin
      w_e = bavg_pkg::WidthW'(bavg_pkg::MaxWidth);
    end else begin
      w_e = image_width_q;
    end
    sq_full = bs_e * bs_e;
  end

  // frame start clear and fold of out-of-range counters
  always_comb begin
    icol_l = frame_start_i ? '0 : icol_q;
    cic_l  = frame_start_i ? '0 : cic_q;
    rib_l  = frame_start_i ? '0 : rib_q;
    hsum_l = frame_start_i ? '0 : hsum_q;
    orc_l  = frame_start_i ? '0 : orc_q;
    if ({1'b0, cic_l} >= bs_e) begin
      cic_l  = '0;
      hsum_l = '0;
    end
    if ({1'b0, rib_l} >= bs_e) begin
      rib_l = '0;
    end
    if ({1'b0, icol_l} >= w_e) begin
      icol_l = '0;
      cic_l  = '0;
      hsum_l = '0;
    end
  end

  // block position flags
  always_comb begin
    bs_m1    = bs_q - bavg_pkg::BlkW'(1);
    blk_end  = {1'b0, cic_q} == bs_m1;
    rib_last = {1'b0, rib_q} == bs_m1;
    in_range = p1_q <= bavg_pkg::ProdW'(w_q);
    p2       = p1_q + bavg_pkg::ProdW'(bs_q);
    last_col = in_range && (p2 > bavg_pkg::ProdW'(w_q));
    hsum_p   = hsum_q + bavg_pkg::HsumW'(px_q);
    sum      = bavg_pkg::SumW'(hsum_p) + ((rib_q != '0) ? rdata_q : '0);
    p1_d     = bavg_pkg::ProdW'({1'b0, oc_q} + bavg_pkg::WidthW'(1))
               * bavg_pkg::ProdW'(bs_q);
    icol_inc = {1'b0, icol_q} + bavg_pkg::WidthW'(1);
  end

  // counter update on load and advance
  always_comb begin
    icol_d = icol_q;
    cic_d  = cic_q;
    rib_d  = rib_q;
    hsum_d = hsum_q;
    orc_d  = orc_q;
    if (cmd_i.load) begin
      icol_d = icol_l;
      cic_d  = cic_l;
      rib_d  = rib_l;
      hsum_d = hsum_l;
      orc_d  = orc_l;
    end else if (cmd_i.adv) begin
      if (in_range) begin
        if (blk_end) begin
          cic_d  = '0;
          hsum_d = '0;
        end else begin
          cic_d  = cic_q + bavg_pkg::CntW'(1);
          hsum_d = hsum_p;
        end
      end
      if (icol_inc >= w_q) begin
        icol_d = '0;
        cic_d  = '0;
        hsum_d = '0;
        if (rib_last) begin
          rib_d = '0;
          orc_d = orc_q + bavg_pkg::ColW'(1);
        end else begin
          rib_d = rib_q + bavg_pkg::CntW'(1);
        end
      end else begin
        icol_d = icol_inc[bavg_pkg::ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icol_q <= '0;
      cic_q  <= '0;
      rib_q  <= '0;
      hsum_q <= '0;
      orc_q  <= '0;
    end else begin
      icol_q <= icol_d;
      cic_q  <= cic_d;
      rib_q  <= rib_d;
      hsum_q <= hsum_d;
      orc_q  <= orc_d;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bs_q  <= bs_e;
      w_q   <= w_e;
      bsq_q <= sq_full[bavg_pkg::SqW-1:0];
      px_q  <= pixel_i;
    end
    if (cmd_i.cap_oc) begin
      oc_q <= div_quo[bavg_pkg::ColW-1:0];
    end
    if (cmd_i.mul) begin
      p1_q <= p1_d;
    end
  end

  // line buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      col_mem[oc_q] <= sum;
    end
    if (cmd_i.mul) begin
      rdata_q <= col_mem[oc_q];
    end
  end

  // shared divider: output column, then block average
  always_comb begin
    div_num = cmd_i.avg_start ? sum : bavg_pkg::DivNW'(icol_q);
    div_den = cmd_i.avg_start ? bsq_q : bavg_pkg::DivDW'(bs_q);
  end

  bavg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.col_start || cmd_i.avg_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      average_q <= div_quo[bavg_pkg::PixW-1:0];
      out_col_q <= oc_q;
      out_row_q <= orc_q;
      row_end_q <= last_col;
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;
  assign out_col_o   = out_col_q;
  assign out_row_o   = out_row_q;
  assign row_end_o   = row_end_q;

  // status to controller
  always_comb begin
    sts_o.div_done = div_done;
    sts_o.in_range = in_range;
    sts_o.blk_end  = blk_end;
    sts_o.rib_last = rib_last;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // counters are folded into range once a transaction is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> ({1'b0, cic_q} < bs_q) && ({1'b0, rib_q} < bs_q)
                   && ({1'b0, icol_q} < w_q))
    else $error("counters out of range after load");

  // the line buffer is only written at a finished block that is not the last block row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr |-> in_range && blk_end && !rib_last)
    else $error("line buffer written outside a block end");

endmodule

// ----- design/bavg_ctrl.sv -----
// controller state machine sequencing one pixel transaction
module bavg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bavg_pkg::bavg_sts_t  sts_i,
  output bavg_pkg::bavg_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_COL_GO   = 8'b0000_0010,
    S_COL_WAIT = 8'b0000_0100,
    S_MUL      = 8'b0000_1000,
    S_EVAL     = 8'b0001_0000,
    S_AVG_GO   = 8'b0010_0000,
    S_AVG_WAIT = 8'b0100_0000,
    S_EMIT     = 8'b1000_0000
  } bavg_state_e;

  bavg_state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_COL_GO;
        end
      end
      S_COL_GO: begin
        cmd_o.col_start = 1'b1;
        state_d         = S_COL_WAIT;
      end
      S_COL_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.cap_oc = 1'b1;
          state_d      = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_EVAL;
      end
      S_EVAL: begin
        if (sts_i.in_range && sts_i.blk_end && sts_i.rib_last) begin
          state_d = S_AVG_GO;
        end else begin
          cmd_o.wr  = sts_i.in_range && sts_i.blk_end;
          cmd_o.adv = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_AVG_GO: begin
        cmd_o.avg_start = 1'b1;
        state_d         = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (sts_i.div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.adv  = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // divider completion only arrives while a division is awaited
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_COL_WAIT || state_q == S_AVG_WAIT))
    else $error("divider done outside a wait state");

  // a result is never loaded over one that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("output register overwritten");

endmodule

// ----- design/block_average_downscaler_top.sv -----
// top level of the block average downscaler
// Box-filter downscaler: 8-bit grayscale pixels enter in raster order and each
// output pixel is the floor of the mean of one block_size x block_size square,
// delivered with its output column, row and a last-in-row flag when the
// block's bottom-right pixel is accepted. Partial blocks at the right and
// bottom edges are dropped. One pixel is processed at a time, and the next is
// not accepted until it is through. A pixel that completes no block runs the
// 16-step serial divider once, to find the output column; one that completes a
// block runs it once more to form the average and may also wait for a stall
// on the output side. The result sits in an output register, so the next
// pixel is taken while it waits. The column-sum line buffer needs no clearing:
// the first row of each block row overwrites it.
// Registers: index 0 block_size (0 acts as 1, above 16 as 16), index 1
// image_width (0 acts as 1, above 4096 as 4096); write them between frames.
module block_average_downscaler_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bavg_pkg::PixW-1:0]       pixel_i,
  input  logic                            frame_start_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bavg_pkg::PixW-1:0]       average_o,
  output logic [bavg_pkg::ColW-1:0]       out_col_o,
  output logic [bavg_pkg::ColW-1:0]       out_row_o,
  output logic                            row_end_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bavg_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bavg_pkg::CfgDataW-1:0]   cfg_data_i
);

  bavg_pkg::bavg_cmd_t cmd;
  bavg_pkg::bavg_sts_t sts;

  // controller
  bavg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  bavg_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .average_o     (average_o),
    .out_col_o     (out_col_o),
    .out_row_o     (out_row_o),
    .row_end_o     (row_end_o)
  );

endmodule

// ----- bench/tb_block_average_downscaler_top.sv -----
// testbench for the block average downscaler: directed and random frames checked against a predictor
`timescale 1ns / 100ps

module tb_block_average_downscaler_top;

  localparam int unsigned SettleCycles = 64;
  localparam int unsigned StuckLimit   = 4000;
  localparam int unsigned RandomTarget = 1350;
  localparam int unsigned HoldCycles   = 400;

  // expected output transaction
  typedef struct packed {
    logic [bavg_pkg::PixW-1:0] average;
    logic [bavg_pkg::ColW-1:0] out_col;
    logic [bavg_pkg::ColW-1:0] out_row;
    logic                      row_end;
  } block_result_t;

  // clock, reset and driven inputs
  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic                          in_valid    = 1'b0;
  logic [bavg_pkg::PixW-1:0]     pixel       = '0;
  logic                          frame_start = 1'b0;
  logic                          out_ready   = 1'b0;
  logic                          cfg_valid   = 1'b0;
  logic [bavg_pkg::CfgIdxW-1:0]  cfg_index   = bavg_pkg::RegBlockSize;
  logic [bavg_pkg::CfgDataW-1:0] cfg_data    = '0;

  logic                          in_ready;
  logic                          out_valid;
  logic [bavg_pkg::PixW-1:0]     average;
  logic [bavg_pkg::ColW-1:0]     out_col;
  logic [bavg_pkg::ColW-1:0]     out_row;
  logic                          row_end;
  logic                          cfg_ready;

  // predictor state, shadow of the registers and the line of partial block sums
  logic [bavg_pkg::BlkW-1:0]   block_size_reg  = bavg_pkg::BlockSizeRst;
  logic [bavg_pkg::WidthW-1:0] image_width_reg = bavg_pkg::ImageWidthRst;
  logic [bavg_pkg::SumW-1:0]   line_sums [bavg_pkg::MaxWidth];
  logic [bavg_pkg::HsumW-1:0]  run_sum    = '0;
  logic [bavg_pkg::WidthW-1:0] col_pos    = '0;
  logic [bavg_pkg::BlkW-1:0]   col_in_blk = '0;
  logic [bavg_pkg::BlkW-1:0]   row_in_blk = '0;
  logic [bavg_pkg::ColW-1:0]   blk_row    = '0;
  block_result_t               expected_blocks [$];
  block_result_t               want;

  // stimulus and bookkeeping
  int unsigned used_pixels    = 0;
  int unsigned fail_count     = 0;
  int unsigned stuck_cycles   = 0;
  int unsigned burst_left     = 0;
  int unsigned hold_request   = 0;
  int unsigned hold_left      = 0;
  int unsigned mask_age       = 0;
  logic [15:0] stall_mask     = 16'hffff;
  bit          sender_gaps_on = 1'b1;
  bit          stall_on       = 1'b1;

  block_average_downscaler_top dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .pixel_i      (pixel),
    .frame_start_i(frame_start),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .average_o    (average),
    .out_col_o    (out_col),
    .out_row_o    (out_row),
    .row_end_o    (row_end),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always #6 clk = ~clk;

  // predict one accepted pixel, queue the block average it completes, return 1 if it was used
  function automatic bit predict_pixel(input logic [bavg_pkg::PixW-1:0] px, input logic fs);
    int unsigned bs, w, per_row, oc, total;
    bit used;
    block_result_t r;
    used = 1'b0;
    bs = (block_size_reg == 0) ? 1 :
         (block_size_reg > bavg_pkg::MaxBlock) ? bavg_pkg::MaxBlock : block_size_reg;
    w = (image_width_reg == 0) ? 1 :
        (image_width_reg > bavg_pkg::MaxWidth) ? bavg_pkg::MaxWidth : image_width_reg;
    per_row = w / bs;
    if (fs) begin
      col_pos    = '0;
      col_in_blk = '0;
      row_in_blk = '0;
      blk_row    = '0;
      run_sum    = '0;
    end
    // fold counters that no longer fit the geometry
    if (col_in_blk >= bs) begin
      col_in_blk = '0;
      run_sum    = '0;
    end
    if (row_in_blk >= bs) row_in_blk = '0;
    if (col_pos >= w) begin
      col_pos    = '0;
      col_in_blk = '0;
      run_sum    = '0;
    end
    // right-edge partial blocks are dropped
    oc = col_pos / bs;
    if (oc < per_row) begin
      used = 1'b1;
      run_sum = run_sum + px;
      if (col_in_blk == bs - 1) begin
        total = run_sum;
        if (row_in_blk != 0) total += line_sums[oc % bavg_pkg::MaxWidth];
        if (row_in_blk == bs - 1) begin
          r.average = bavg_pkg::PixW'(total / (bs * bs));
          r.out_col = bavg_pkg::ColW'(oc);
          r.out_row = blk_row;
          r.row_end = (oc == per_row - 1);
          expected_blocks.push_back(r);
        end else begin
          line_sums[oc % bavg_pkg::MaxWidth] = bavg_pkg::SumW'(total);
        end
        run_sum    = '0;
        col_in_blk = '0;
      end else begin
        col_in_blk++;
      end
    end
    // end of input row
    col_pos++;
    if (col_pos >= w) begin
      col_pos    = '0;
      col_in_blk = '0;
      run_sum    = '0;
      row_in_blk++;
      if (row_in_blk >= bs) begin
        row_in_blk = '0;
        blk_row++;
      end
    end
    return used;
  endfunction

  // offer one pixel, with random gaps between bursts
  task automatic send_pixel(input logic [bavg_pkg::PixW-1:0] px, input logic fs);
    int unsigned gap;
    @(negedge clk);
    if (sender_gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid    <= 1'b1;
    pixel       <= px;
    frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    if (predict_pixel(px, fs)) used_pixels++;
    if (burst_left > 0) burst_left--;
  endtask

  // stop offering and wait until every queued average has arrived
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
  endtask

  // drained, then let a pixel that completes no block finish
  task automatic wait_block_idle();
    drain_results();
    repeat (SettleCycles) @(posedge clk);
  endtask

  // one register write transaction
  task automatic write_reg(input logic [bavg_pkg::CfgIdxW-1:0] idx,
                           input logic [bavg_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == bavg_pkg::RegBlockSize) block_size_reg = val[bavg_pkg::BlkW-1:0];
    else image_width_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input int unsigned bs_raw, input int unsigned w_raw);
    wait_block_idle();
    write_reg(bavg_pkg::RegBlockSize, bavg_pkg::CfgDataW'(bs_raw));
    write_reg(bavg_pkg::RegImageWidth, bavg_pkg::CfgDataW'(w_raw));
  endtask

  // 2x2 blocks with a dropped right-edge column and pixel extremes
  task automatic test_full_blocks();
    int unsigned vals [10] = '{255, 255, 0, 0, 77, 255, 255, 0, 1, 99};
    int i;
    set_geometry(2, 5);
    for (i = 0; i < 10; i++) send_pixel(bavg_pkg::PixW'(vals[i]), i == 0);
  endtask

  // zero block size and zero width act as one: every pixel is its own block
  task automatic test_unit_blocks();
    int unsigned vals [3] = '{0, 255, 170};
    int i;
    set_geometry(0, 0);
    for (i = 0; i < 3; i++) send_pixel(bavg_pkg::PixW'(vals[i]), i == 0);
  endtask

  // width below block size never emits, frame start in the middle of a row
  task automatic test_narrow_image();
    int i;
    set_geometry(3, 2);
    for (i = 0; i < 6; i++) begin
      send_pixel(bavg_pkg::PixW'($urandom_range(0, 255)), i == 0 || i == 3);
    end
  endtask

  // register values above the maximum act as the maximum
  task automatic test_largest_geometry();
    int i;
    set_geometry(31, 8191);
    for (i = 0; i < 4; i++) send_pixel(8'hff, i == 0);
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_output_backpressure();
    int i;
    set_geometry(1, 7);
    sender_gaps_on = 1'b0;
    stall_on = 1'b0;
    hold_request = HoldCycles;
    for (i = 0; i < 24; i++) send_pixel(bavg_pkg::PixW'($urandom_range(0, 255)), i == 0);
  endtask

  // sender pauses mid frame until every expected average has come
  task automatic test_input_pause();
    int i;
    set_geometry(2, 6);
    sender_gaps_on = 1'b1;
    stall_on = 1'b1;
    for (i = 0; i < 24; i++) begin
      send_pixel(bavg_pkg::PixW'($urandom_range(0, 255)), i == 0);
      if (i == 7 || i == 15) drain_results();
    end
  endtask

  // one random geometry and one frame, mostly well formed
  task automatic random_frame();
    int unsigned cls, bs, w, rows, npix, mode, bs_raw, w_raw, i;
    bit noise, fs;
    logic [bavg_pkg::PixW-1:0] px;
    cls = $urandom_range(0, 9);
    if (cls < 7) bs = $urandom_range(1, 4);
    else if (cls < 9) bs = $urandom_range(5, 8);
    else bs = $urandom_range(9, 16);
    if (bs <= 4) w = $urandom_range(bs, bs * 6 + 3);
    else w = $urandom_range(bs, bs + 3);
    if (bs > 1 && $urandom_range(0, 15) == 0) w = $urandom_range(1, bs - 1);
    rows = bs * ((bs <= 4) ? $urandom_range(1, 3) : 1);
    if ($urandom_range(0, 4) == 0) rows += $urandom_range(0, bs - 1);
    npix = rows * w;
    // out-of-range register values for the effective extremes
    bs_raw = bs;
    if (bs == 1 && $urandom_range(0, 1)) bs_raw = 0;
    if (bs == 16 && $urandom_range(0, 1)) bs_raw = $urandom_range(17, 31);
    w_raw = w;
    if (w == 1 && $urandom_range(0, 1)) w_raw = 0;
    mode = $urandom_range(0, 5);
    noise = ($urandom_range(0, 4) == 0);
    if (noise) npix = $urandom_range(1, npix);
    set_geometry(bs_raw, w_raw);
    sender_gaps_on = ($urandom_range(0, 3) != 0);
    stall_on = ($urandom_range(0, 3) != 0);
    for (i = 0; i < npix; i++) begin
      case (mode)
        0: px = 8'hff;
        1: px = 8'h00;
        2: px = $urandom_range(0, 1) ? 8'hff : 8'h00;
        default: px = bavg_pkg::PixW'($urandom_range(0, 255));
      endcase
      fs = (i == 0) || (noise && $urandom_range(0, 40) == 0);
      send_pixel(px, fs);
    end
  endtask

  task automatic test_random_frames();
    while (used_pixels < RandomTarget) random_frame();
  endtask

  // receiver: random stall pattern, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (mask_age == 0) stall_mask = 16'($urandom | $urandom);
    mask_age = (mask_age + 1) % 64;
    stall_mask = {stall_mask[14:0], stall_mask[15]};
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !stall_on || stall_mask[0];
    end
  end

  // compare each output transaction with the oldest expected average
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_blocks.size() == 0) begin
        $error("output with none expected: average %0d col %0d row %0d", average, out_col,
               out_row);
        fail_count++;
      end else begin
        want = expected_blocks.pop_front();
        if (average !== want.average) begin
          $error("average: expected %0d, got %0d", want.average, average);
          fail_count++;
        end
        if (out_col !== want.out_col) begin
          $error("out_col: expected %0d, got %0d", want.out_col, out_col);
          fail_count++;
        end
        if (out_row !== want.out_row) begin
          $error("out_row: expected %0d, got %0d", want.out_row, out_row);
          fail_count++;
        end
        if (row_end !== want.row_end) begin
          $error("row_end: expected %0d, got %0d", want.row_end, row_end);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= StuckLimit) begin
      $display("tb_block_average_downscaler_top failed");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_full_blocks();
    test_unit_blocks();
    test_narrow_image();
    test_largest_geometry();
    test_output_backpressure();
    test_input_pause();
    test_random_frames();
    wait_block_idle();
    if (fail_count == 0) begin
      $display("tb_block_average_downscaler_top passed");
    end else begin
      $display("tb_block_average_downscaler_top failed");
    end
    $finish;
  end

endmodule
